// ===== hdl/assert_macros.svh =====
// assertion macros used by the port checks in hdl/udr_checker.sv
// no dependencies; each macro expects clk and arst_n in the calling scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every rising clock edge outside reset
`define UDR_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error(msg);

// antecedent in one cycle implies consequent in the next
`define UDR_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hdl/udr_pkg.sv =====
// widths, stage payload types and the restoring step for the divider
// no dependencies; imported by every module of the divider
package udr_pkg;

	localparam int DATA_WIDTH = 32;
	localparam int FIELD_W    = 32;
	localparam int S_TDATA_W  = 2 * FIELD_W;
	localparam int M_TDATA_W  = 2 * FIELD_W;

	// partial state of one division in flight
	typedef struct packed {
		logic [DATA_WIDTH-1:0] q;
		logic [DATA_WIDTH-1:0] r;
		logic [DATA_WIDTH-1:0] d;
		logic                  dz;
	} udr_stage_t;

	typedef struct packed {
		logic [FIELD_W-1:0] remainder;
		logic [FIELD_W-1:0] quotient;
	} udr_result_t;

	// one restoring step: shift in the next dividend bit, subtract if it fits
	function automatic udr_stage_t udr_step(input udr_stage_t x);
		logic [DATA_WIDTH:0]   trial;
		logic [DATA_WIDTH+1:0] diff;
		logic                  take;
		udr_stage_t            y;
		trial = {x.r, x.q[DATA_WIDTH-1]};
		diff  = {1'b0, trial} - {2'b00, x.d};
		take  = ~diff[DATA_WIDTH+1];
		y.q   = {x.q[DATA_WIDTH-2:0], take};
		y.r   = take ? diff[DATA_WIDTH-1:0] : trial[DATA_WIDTH-1:0];
		y.d   = x.d;
		y.dz  = x.dz;
		return y;
	endfunction

endpackage

// ===== hdl/udr_stage.sv =====
// one register stage of the divider pipeline, one quotient bit per stage
// depends on udr_pkg for the payload type and the step function
module udr_stage import udr_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       en,
	input  logic       in_valid,
	input  udr_stage_t in_data,
	output logic       out_valid,
	output udr_stage_t out_data
);

	// registers of this stage of the chain
	logic       valid_sn;
	udr_stage_t data_sn;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_sn <= 1'b0;
		end else if (en) begin
			valid_sn <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			data_sn <= udr_step(in_data);
		end
	end

	assign out_valid = valid_sn;
	assign out_data  = data_sn;

endmodule

// ===== hdl/udr_skid.sv =====
// output register with a skid entry, parts pipeline advance from the downstream ready
// depends on udr_pkg for the result type
module udr_skid import udr_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  udr_result_t in_data,
	output logic        out_valid,
	input  logic        out_ready,
	output udr_result_t out_data
);

	logic        out_valid_q;
	logic        skid_valid_q;
	udr_result_t out_data_q;
	udr_result_t skid_data_q;
	logic        load_out;

	assign in_ready = ~skid_valid_q;
	assign load_out = ~out_valid_q | out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q  <= skid_valid_q | in_valid;
			skid_valid_q <= 1'b0;
		end else if (in_valid && !skid_valid_q) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_data_q <= skid_valid_q ? skid_data_q : in_data;
		end else if (in_valid && !skid_valid_q) begin
			skid_data_q <= in_data;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

endmodule

// ===== hdl/unsigned_divide_remainder.sv =====
// top level of the pipelined unsigned restoring divider
// depends on udr_pkg, udr_stage and udr_skid
// a request passes the stage registers and then the output register on its way to m_tvalid
// throughput: one request per cycle while the skid entry is free, one restoring stage per quotient bit
// a stalled output holds the whole pipeline once the skid entry is full
// reset: arst_n clears all valid bits, data registers are not reset
module unsigned_divide_remainder import udr_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [S_TDATA_W-1:0] s_tdata,   // dividend[31:0], divisor[63:32]
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [M_TDATA_W-1:0] m_tdata    // quotient[31:0], remainder[63:32]
);

	// pipeline taps: index 0 is the incoming request, index DATA_WIDTH the last stage
	logic       pipe_valid [0:DATA_WIDTH];
	udr_stage_t pipe_data  [0:DATA_WIDTH];

	// the whole chain moves together whenever the skid entry is free
	logic        pipe_en;
	udr_stage_t  in_stage;
	udr_result_t result;
	udr_result_t out_result;

	assign s_tready = pipe_en;

	// operands are taken at the operand width; the quotient starts as the dividend
	always_comb begin
		in_stage.q  = DATA_WIDTH'(s_tdata[FIELD_W-1:0]);
		in_stage.r  = '0;
		in_stage.d  = DATA_WIDTH'(s_tdata[S_TDATA_W-1:FIELD_W]);
		in_stage.dz = (DATA_WIDTH'(s_tdata[S_TDATA_W-1:FIELD_W]) == '0);
	end

	assign pipe_valid[0] = s_tvalid;
	assign pipe_data[0]  = in_stage;

	// one restoring step per stage
	for (genvar i = 0; i < DATA_WIDTH; i++) begin : g_stage
		udr_stage u_stage (
			.clk       (clk),
			.arst_n    (arst_n),
			.en        (pipe_en),
			.in_valid  (pipe_valid[i]),
			.in_data   (pipe_data[i]),
			.out_valid (pipe_valid[i+1]),
			.out_data  (pipe_data[i+1])
		);
	end

	// zero divisor: all-ones quotient at the operand width and a zero remainder
	always_comb begin
		if (pipe_data[DATA_WIDTH].dz) begin
			result.quotient  = FIELD_W'({DATA_WIDTH{1'b1}});
			result.remainder = '0;
		end else begin
			result.quotient  = FIELD_W'(pipe_data[DATA_WIDTH].q);
			result.remainder = FIELD_W'(pipe_data[DATA_WIDTH].r);
		end
	end

	// output register plus skid entry
	udr_skid u_skid (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (pipe_valid[DATA_WIDTH]),
		.in_ready  (pipe_en),
		.in_data   (result),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_data  (out_result)
	);

	assign m_tdata = {out_result.remainder, out_result.quotient};

endmodule

// ===== hdl/udr_checker.sv =====
// port-level checks of the divider handshake and skid behavior
// depends on udr_pkg and assert_macros.svh; bound to unsigned_divide_remainder
`include "assert_macros.svh"

module udr_port_checks import udr_pkg::*; (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 s_tvalid,
	input logic                 s_tready,
	input logic                 m_tvalid,
	input logic                 m_tready,
	input logic [M_TDATA_W-1:0] m_tdata
);

	// a stalled result holds
	`UDR_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "held")

	// the input side only backs off while a result waits behind a full skid
	`UDR_ASSERT(a_stall_has_output, !s_tready |-> m_tvalid, "input stalled with no result")

	// one taken result frees the skid entry
	`UDR_ASSERT_NEXT(a_stall_release, !s_tready && m_tready, s_tready, "input stayed stalled")

	// the skid fills only when the output was stalled
	`UDR_ASSERT(a_stall_cause, $fell(s_tready) |-> $past(m_tvalid && !m_tready), "bad stall")

endmodule

bind unsigned_divide_remainder udr_port_checks u_udr_checker (.*);

// ===== verif/udr_checker.sv =====
// scoreboard for the unsigned divider: predicts quotient and remainder per request
// depends on udr_pkg; instantiated beside the divider by the testbench top
`timescale 1ns / 100ps

module udr_checker import udr_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	input  logic                 s_tready,
	input  logic [S_TDATA_W-1:0] s_tdata,   // dividend[31:0], divisor[63:32]
	input  logic                 m_tvalid,
	input  logic                 m_tready,
	input  logic [M_TDATA_W-1:0] m_tdata,   // quotient[31:0], remainder[63:32]
	output int                   failures,
	output int                   in_flight
);

	udr_result_t pending_results[$];

	// bit-serial restoring division with a one bit wider partial remainder
	function automatic udr_result_t divide_restoring(input logic [FIELD_W-1:0] dividend,
			input logic [FIELD_W-1:0] divisor);
		logic [DATA_WIDTH-1:0] quo;
		logic [DATA_WIDTH-1:0] den;
		logic [DATA_WIDTH:0]   part;
		udr_result_t           res;
		quo  = DATA_WIDTH'(dividend);
		den  = DATA_WIDTH'(divisor);
		part = '0;
		if (den == '0) begin
			res.quotient  = FIELD_W'({DATA_WIDTH{1'b1}});
			res.remainder = '0;
			return res;
		end
		for (int i = 0; i < DATA_WIDTH; i++) begin
			part = {part[DATA_WIDTH-1:0], quo[DATA_WIDTH-1]};
			quo  = quo << 1;
			if (part >= {1'b0, den}) begin
				part   = part - {1'b0, den};
				quo[0] = 1'b1;
			end
		end
		res.quotient  = FIELD_W'(quo);
		res.remainder = FIELD_W'(part[DATA_WIDTH-1:0]);
		return res;
	endfunction

	initial begin
		failures  = 0;
		in_flight = 0;
	end

	always @(posedge clk) begin
		udr_result_t want;
		udr_result_t got;
		int          errs;
		errs = 0;
		if (arst_n) begin
			if (s_tvalid && s_tready)
				pending_results.push_back(divide_restoring(s_tdata[FIELD_W-1:0],
					s_tdata[2*FIELD_W-1:FIELD_W]));
			if (m_tvalid && m_tready) begin
				got = m_tdata;
				if (pending_results.size() == 0) begin
					$error("result with no request outstanding: quotient %h remainder %h",
						got.quotient, got.remainder);
					errs++;
				end else begin
					want = pending_results.pop_front();
					if (got.quotient !== want.quotient) begin
						$error("quotient mismatch: expected %h, actual %h",
							want.quotient, got.quotient);
						errs++;
					end
					if (got.remainder !== want.remainder) begin
						$error("remainder mismatch: expected %h, actual %h",
							want.remainder, got.remainder);
						errs++;
					end
				end
			end
			if (errs != 0)
				failures <= failures + errs;
			in_flight <= pending_results.size();
		end
	end

endmodule

// ===== verif/testbench.sv =====
// top of the divider testbench: clock, reset, request stimulus and verdict
// depends on udr_pkg, unsigned_divide_remainder and udr_checker
`timescale 1ns / 100ps

module testbench;
	import udr_pkg::*;

	localparam int CYCLE_LIMIT = 200000;
	localparam int RANDOM_PER_PHASE = 200;
	// final wait covers the stage registers, the output register and the skid entry
	localparam int DRAIN_CYCLES = 40;

	logic                 clk      = 1'b0;
	logic                 arst_n   = 1'b0;
	logic                 s_tvalid = 1'b0;
	logic                 s_tready;
	logic [S_TDATA_W-1:0] s_tdata  = '0;   // dividend[31:0], divisor[63:32]
	logic                 m_tvalid;
	logic                 m_tready = 1'b0;
	logic [M_TDATA_W-1:0] m_tdata;         // quotient[31:0], remainder[63:32]

	int failures;
	int in_flight;
	int cycle_count = 0;
	int send_idle   = 30;   // percent of cycles the sender holds back
	int recv_idle   = 81;   // percent of cycles the receiver stalls

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	unsigned_divide_remainder i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	udr_checker i_checker (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.failures  (failures),
		.in_flight (in_flight)
	);

	// receiver back-pressure, redrawn every cycle
	always @(negedge clk) begin
		m_tready <= ($urandom_range(99) >= recv_idle);
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	// operand with a spread of magnitudes: tiny, top-heavy, near max, shifted, full range
	function automatic logic [FIELD_W-1:0] rand_operand();
		logic [FIELD_W-1:0] val;
		case ($urandom_range(5))
			0:       val = FIELD_W'($urandom_range(15));
			1:       val = {1'b1, (FIELD_W-1)'($urandom)};
			2:       val = '1 - FIELD_W'($urandom_range(15));
			3:       val = FIELD_W'($urandom) >> $urandom_range(31);
			default: val = FIELD_W'($urandom);
		endcase
		return val;
	endfunction

	// entered and left at a falling edge; valid stays up after the accept
	task automatic send_division(input logic [FIELD_W-1:0] dividend,
			input logic [FIELD_W-1:0] divisor);
		while ($urandom_range(99) < send_idle) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {divisor, dividend};
		do
			@(posedge clk);
		while (!s_tready);
		@(negedge clk);
	endtask

	// stop requesting and wait until every predicted result has come back
	task automatic drain_results();
		s_tvalid <= 1'b0;
		@(negedge clk);
		while (in_flight != 0)
			@(negedge clk);
	endtask

	initial begin
		int send_pct[3];
		int recv_pct[3];
		send_pct = '{30, 81, 0};
		recv_pct = '{81, 30, 0};

		repeat (12) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed corners: zero divisor, divisor above dividend, divisors at or above 2^31
		send_division(32'h0000_0000, 32'h0000_0000);
		send_division(32'hFFFF_FFFF, 32'h0000_0000);
		send_division(32'h0000_0007, 32'h0000_0000);
		send_division(32'h0000_0000, 32'h0000_0001);
		send_division(32'h0000_0000, 32'hFFFF_FFFF);
		send_division(32'hFFFF_FFFF, 32'h0000_0001);
		send_division(32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_division(32'hFFFF_FFFE, 32'hFFFF_FFFF);
		send_division(32'hFFFF_FFFF, 32'h8000_0000);
		send_division(32'hFFFF_FFFF, 32'h8000_0001);
		send_division(32'h8000_0000, 32'h8000_0001);
		send_division(32'h8000_0000, 32'h8000_0000);
		send_division(32'h0000_0001, 32'h0000_0001);
		send_division(32'h0000_0005, 32'h0000_0009);
		send_division(32'h1234_5678, 32'h0000_0010);
		send_division(32'hFFFF_FFFF, 32'h0000_0003);
		send_division(32'hDEAD_BEEF, 32'h0001_0000);
		send_division(32'h7FFF_FFFF, 32'h0000_0002);
		send_division(32'h5555_5555, 32'hAAAA_AAAA);
		send_division(32'hAAAA_AAAA, 32'h5555_5555);

		// hold off until the pipeline is empty before the random part
		drain_results();

		// random operands under three idling profiles, ending with none
		for (int ph = 0; ph < 3; ph++) begin
			send_idle = send_pct[ph];
			recv_idle = recv_pct[ph];
			repeat (RANDOM_PER_PHASE)
				send_division(rand_operand(), rand_operand());
			drain_results();
		end

		// catch any stray result after the last expected one
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (failures == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
